FILE: rtl/core/lfps_pkg.sv
package lfps_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASE_SPEED = 3'd0;
    localparam logic [2:0] CFG_TURN_SPEED = 3'd1;
    localparam logic [2:0] CFG_GAIN_P     = 3'd2;
    localparam logic [2:0] CFG_GAIN_I     = 3'd3;
    localparam logic [2:0] CFG_GAIN_D     = 3'd4;

    localparam logic [7:0]         RST_BASE_SPEED = 8'd0;
    localparam logic [6:0]         RST_TURN_SPEED = 7'd15;
    localparam logic signed [15:0] RST_GAIN_P     = 16'sd1280;
    localparam logic signed [15:0] RST_GAIN_I     = 16'sd256;
    localparam logic signed [15:0] RST_GAIN_D     = 16'sd0;

    localparam logic [7:0] PATTERN_LOST   = 8'hFF;
    localparam logic [7:0] PATTERN_CENTER = 8'hE7;

    localparam logic signed [15:0] STEER_MAX = 16'sh7FFF;
    localparam logic signed [15:0] STEER_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] i;
        logic signed [15:0] d;
    } t_gains;

    // Command side info carried beside the PID operands
    typedef struct packed {
        logic [7:0]         speed;
        logic               turning;
        logic               use_pid;
        logic signed [15:0] fixed_steer;
    } t_cmd;

    typedef struct packed {
        logic signed [3:0] err;
        logic signed [4:0] diff;
    } t_pid_ops;

    typedef struct packed {
        logic              hit;
        logic signed [3:0] err;
    } t_map;

    function automatic t_map map_pattern(input logic [7:0] b);
        t_map m;
        m.hit = 1'b1;
        case (b)
            8'hE7:   m.err = 4'sd0;
            8'hEF:   m.err = 4'sd1;
            8'hCF:   m.err = 4'sd2;
            8'hDF:   m.err = 4'sd3;
            8'h9F:   m.err = 4'sd4;
            8'hBF:   m.err = 4'sd5;
            8'h3F:   m.err = 4'sd6;
            8'h7F:   m.err = 4'sd7;
            8'hF7:   m.err = -4'sd1;
            8'hF3:   m.err = -4'sd2;
            8'hFB:   m.err = -4'sd3;
            8'hF9:   m.err = -4'sd4;
            8'hFD:   m.err = -4'sd5;
            8'hFC:   m.err = -4'sd6;
            8'hFE:   m.err = -4'sd7;
            default: begin
                m.hit = 1'b0;
                m.err = 4'sd0;
            end
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/lfps_pid_pipe.sv
module lfps_pid_pipe #(
    parameter int SUM_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lfps_pkg::t_pid_ops          i_ops,
    input  logic signed [SUM_WIDTH-1:0] i_sum,
    input  lfps_pkg::t_cmd              i_cmd,
    input  lfps_pkg::t_gains            i_gains,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_speed,
    output logic signed [15:0]          o_steer,
    output logic                        o_turning
);
    import lfps_pkg::*;

    localparam int AW = SUM_WIDTH + 18;
    localparam logic signed [AW-1:0] Q_MAX = AW'(STEER_MAX);
    localparam logic signed [AW-1:0] Q_MIN = AW'(STEER_MIN);

    // stage a: products
    logic                          r_a_valid;
    t_cmd                          r_a_cmd;
    logic signed [19:0]            r_prod_p;
    logic signed [SUM_WIDTH+15:0]  r_prod_i;
    logic signed [20:0]            r_prod_d;
    // stage b: sum of products
    logic                          r_b_valid;
    t_cmd                          r_b_cmd;
    logic signed [AW-1:0]          r_acc;
    // stage c: result
    logic                          r_c_valid;
    logic [7:0]                    r_speed;
    logic signed [15:0]            r_steer;
    logic                          r_turning;

    logic                 w_ready_a;
    logic                 w_ready_b;
    logic                 w_ready_c;
    logic signed [AW-1:0] w_adj;
    logic signed [AW-1:0] w_q;
    logic signed [15:0]   w_pid_steer;

    assign w_ready_c = !r_c_valid || i_ready;
    assign w_ready_b = !r_b_valid || w_ready_c;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // truncate toward zero: bias negatives by 255 before the shift
    assign w_adj = r_acc + $signed({{(AW-8){1'b0}}, {8{r_acc[AW-1]}}});
    assign w_q   = w_adj >>> 8;

    always_comb begin
        if (w_q > Q_MAX) begin
            w_pid_steer = STEER_MAX;
        end else if (w_q < Q_MIN) begin
            w_pid_steer = STEER_MIN;
        end else begin
            w_pid_steer = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_cmd  <= i_cmd;
            r_prod_p <= i_gains.p * i_ops.err;
            r_prod_i <= i_gains.i * i_sum;
            r_prod_d <= i_gains.d * i_ops.diff;
        end
        if (w_ready_b && r_a_valid) begin
            r_b_cmd <= r_a_cmd;
            r_acc   <= AW'(r_prod_p) + AW'(r_prod_i) + AW'(r_prod_d);
        end
        if (w_ready_c && r_b_valid) begin
            r_speed   <= r_b_cmd.speed;
            r_turning <= r_b_cmd.turning;
            r_steer   <= r_b_cmd.use_pid ? w_pid_steer : r_b_cmd.fixed_steer;
        end
    end

    assign o_valid   = r_c_valid;
    assign o_speed   = r_speed;
    assign o_steer   = r_steer;
    assign o_turning = r_turning;

endmodule

FILE: rtl/core/line_follow_pid_steering_core.sv
// Line-follower PID steering core. Each transfer on the sensor stream carries one
// active-low sensor byte (bit 7 leftmost, 0 = line seen) and yields exactly one
// command transfer on the master side. The core takes one sensor byte per clock
// and keeps that rate for as long as results are taken; the result of a byte
// passes in turn through the input register, state update, products, product sum
// and truncate/saturate registers. The loop that sets the rate is the state
// update stage: pattern lookup, error and integral update with saturation, and
// edge/turn mode bookkeeping, all combinational and registered with the byte, so the next byte sees it.
// Each of the five registers along the path holds one item, so input transfers continue
// while an output waits, until the pipe is full. Gains are signed Q8.8; steer is the
// PID sum shifted right by 8 (toward zero) and saturated to 16 bits. Write
// configuration only while the core is idle; writes to unknown indexes are
// accepted and dropped.
module line_follow_pid_steering_core #(
    parameter int SUM_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sensor stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] sensor_bits
    // command stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] drive_speed, [23:8] steer
    output logic [0:0]  o_m_tuser,   // [0] turning
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lfps_pkg::*;

    // integral saturation limits, one bit wider than the sum
    localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

    // configuration
    logic [7:0] r_base_speed;
    logic [6:0] r_turn_speed;
    t_gains     r_gains;

    // controller state
    logic signed [3:0]           r_pos_err;
    logic signed [3:0]           r_prev_err;
    logic signed [SUM_WIDTH-1:0] r_err_sum;
    logic                        r_last_left;
    logic                        r_turn_mode;

    logic signed [3:0]           n_pos_err;
    logic signed [3:0]           n_prev_err;
    logic signed [SUM_WIDTH-1:0] n_err_sum;
    logic                        n_last_left;
    logic                        n_turn_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_sensor;

    // operand register feeding the PID pipe
    logic                        r_op_valid;
    t_cmd                        r_cmd;
    t_pid_ops                    r_ops;
    logic signed [SUM_WIDTH-1:0] r_sum;
    t_cmd                        n_cmd;
    t_pid_ops                    n_ops;

    logic                        w_pipe_ready;
    logic                        w_op_ready;
    logic                        w_advance;
    t_map                        w_map;
    logic signed [SUM_WIDTH-1:0] w_sum_base;
    logic signed [SUM_WIDTH:0]   w_sum_wide;
    logic signed [15:0]          w_turn_steer;
    logic [7:0]                  w_speed;
    logic signed [15:0]          w_steer;
    logic                        w_turning;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed <= RST_BASE_SPEED;
            r_turn_speed <= RST_TURN_SPEED;
            r_gains.p    <= RST_GAIN_P;
            r_gains.i    <= RST_GAIN_I;
            r_gains.d    <= RST_GAIN_D;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data[7:0];
                CFG_TURN_SPEED: r_turn_speed <= i_cfg_data[6:0];
                CFG_GAIN_P:     r_gains.p    <= i_cfg_data;
                CFG_GAIN_I:     r_gains.i    <= i_cfg_data;
                CFG_GAIN_D:     r_gains.d    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // handshake chain: each stage frees when empty or moving on
    assign w_op_ready = !r_op_valid || w_pipe_ready;
    assign o_s_tready = !r_in_valid || w_op_ready;
    assign w_advance  = r_in_valid && w_op_ready;

    assign w_map        = map_pattern(r_in_sensor);
    assign w_turn_steer = r_last_left ? $signed({9'd0, r_turn_speed})
                                      : -$signed({9'd0, r_turn_speed});

    // state update for the byte in the input register
    always_comb begin
        n_pos_err   = r_pos_err;
        n_prev_err  = r_prev_err;
        n_err_sum   = r_err_sum;
        n_last_left = r_last_left;
        n_turn_mode = r_turn_mode;
        w_sum_base  = r_err_sum;
        w_sum_wide  = '0;
        w_speed     = r_base_speed;
        w_steer     = '0;
        w_turning   = 1'b0;
        n_ops.err   = r_pos_err;
        n_ops.diff  = '0;

        if (r_turn_mode) begin
            // spinning in place; a centre sensor ends the search
            w_speed = '0;
            w_steer = w_turn_steer;
            if (!r_in_sensor[4] || !r_in_sensor[3]) begin
                n_turn_mode = 1'b0;
            end
            w_turning = n_turn_mode;
        end else if (r_in_sensor == PATTERN_LOST) begin
            n_turn_mode = 1'b1;
            n_err_sum   = '0;
            w_turning   = 1'b1;
        end else begin
            if (w_map.hit) begin
                n_pos_err = w_map.err;
            end
            if (r_in_sensor == PATTERN_CENTER) begin
                w_sum_base = '0;
            end
            if (!r_in_sensor[7]) begin
                n_last_left = 1'b1;
            end else if (!r_in_sensor[0]) begin
                n_last_left = 1'b0;
            end
            w_sum_wide = (SUM_WIDTH+1)'(w_sum_base) + (SUM_WIDTH+1)'(n_pos_err);
            if (w_sum_wide > SUM_MAX) begin
                n_err_sum = SUM_MAX[SUM_WIDTH-1:0];
            end else if (w_sum_wide < SUM_MIN) begin
                n_err_sum = SUM_MIN[SUM_WIDTH-1:0];
            end else begin
                n_err_sum = w_sum_wide[SUM_WIDTH-1:0];
            end
            n_ops.err  = n_pos_err;
            n_ops.diff = 5'(n_pos_err) - 5'(r_prev_err);
            n_prev_err = n_pos_err;
        end

        n_cmd.speed       = w_speed;
        n_cmd.turning     = w_turning;
        n_cmd.use_pid     = !r_turn_mode && (r_in_sensor != PATTERN_LOST);
        n_cmd.fixed_steer = w_steer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_op_valid  <= 1'b0;
            r_pos_err   <= '0;
            r_prev_err  <= '0;
            r_err_sum   <= '0;
            r_last_left <= 1'b0;
            r_turn_mode <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_op_ready) begin
                r_op_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_pos_err   <= n_pos_err;
                r_prev_err  <= n_prev_err;
                r_err_sum   <= n_err_sum;
                r_last_left <= n_last_left;
                r_turn_mode <= n_turn_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_sensor <= i_s_tdata;
        end
        if (w_advance) begin
            r_cmd <= n_cmd;
            r_ops <= n_ops;
            r_sum <= n_err_sum;
        end
    end

    lfps_pid_pipe #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_pid_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_op_valid),
        .o_ready   (w_pipe_ready),
        .i_ops     (r_ops),
        .i_sum     (r_sum),
        .i_cmd     (r_cmd),
        .i_gains   (r_gains),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_speed   (o_m_tdata[7:0]),
        .o_steer   (o_m_tdata[23:8]),
        .o_turning (o_m_tuser[0])
    );

endmodule
